// ===== hw/rtl/tiltq_pkg.sv =====
// shared types, constants and fixed-point helpers for the tilt-to-quaternion unit
package tiltq_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_RUN = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int STEP_W = $clog2(ATAN_ENTRIES);
   localparam int QW = 34;
   localparam int AW = 36;

   localparam logic signed [QW-1:0] Q30_GAIN = 34'sd652032874;
   localparam logic signed [AW-1:0] Q30_PI = 36'sd3373259426;
   localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;

   localparam logic REG_FIRST_HEADING = 1'b0;
   localparam logic REG_SECOND_HEADING = 1'b1;

   typedef logic signed [QW-1:0] q30_type;

   typedef struct packed {
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
      logic                 neg;
   } lane_type;

   function automatic q30_type atan_q30(input logic [STEP_W-1:0] idx);
      q30_type r;
      case (idx)
         5'd0: r = 34'sd843314856;
         5'd1: r = 34'sd497837829;
         5'd2: r = 34'sd263043836;
         5'd3: r = 34'sd133525158;
         5'd4: r = 34'sd67021686;
         5'd5: r = 34'sd33543515;
         5'd6: r = 34'sd16775850;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194282;
         5'd9: r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // q30 product, rounded half up
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [2*QW-1:0] p;
      p = a * b;
      p = p + (68'sd1 <<< 29);
      return p[QW+29:30];
   endfunction

   // q30 to q14 with rounding and saturation
   function automatic logic signed [15:0] to_q14(input q30_type v);
      logic signed [QW:0] t;
      logic signed [QW-16:0] r;
      t = {v[QW-1], v} + 35'sd32768;
      r = t[QW:16];
      if (r > 19'sd16384) r = 19'sd16384;
      if (r < -19'sd16384) r = -19'sd16384;
      return r[15:0];
   endfunction

endpackage

// ===== hw/rtl/tiltq_cordic_cell.sv =====
// one rotation-mode cordic iteration, registered
module tiltq_cordic_cell (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tiltq_pkg::STEP_W-1:0] step,
   input  tiltq_pkg::lane_type         cell_in,
   output tiltq_pkg::lane_type         cell_out
);
   import tiltq_pkg::*;

   lane_type stage_ff, stage_in;
   q30_type  dx, dy, at;

   always_comb begin
      dx = cell_in.y >>> step;
      dy = cell_in.x >>> step;
      at = atan_q30(step);
      stage_in = cell_in;
      if (!cell_in.z[QW-1]) begin
         stage_in.x = cell_in.x - dx;
         stage_in.y = cell_in.y + dy;
         stage_in.z = cell_in.z - at;
      end else begin
         stage_in.x = cell_in.x + dx;
         stage_in.y = cell_in.y - dy;
         stage_in.z = cell_in.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) stage_ff <= stage_in;
   end

   assign cell_out = stage_ff;
endmodule

// ===== hw/rtl/tiltq_hamilton.sv =====
// two-stage hamilton product: rounded partial products, then sums
module tiltq_hamilton (
   input  logic               clock,
   input  logic               en,
   input  tiltq_pkg::q30_type a [4],
   input  tiltq_pkg::q30_type b [4],
   output tiltq_pkg::q30_type r [4]
);
   import tiltq_pkg::*;

   q30_type m_ff [16];
   q30_type r_ff [4];
   q30_type r_in [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               m_ff[4*i+j] <= qmul(a[i], b[j]);
            end
         end
         r_ff <= r_in;
      end
   end

   always_comb begin
      r_in[0] = m_ff[0] - m_ff[5] - m_ff[10] - m_ff[15];
      r_in[1] = m_ff[1] + m_ff[4] + m_ff[11] - m_ff[14];
      r_in[2] = m_ff[2] - m_ff[7] + m_ff[8] + m_ff[13];
      r_in[3] = m_ff[3] + m_ff[6] - m_ff[9] + m_ff[12];
   end

   assign r = r_ff;
endmodule

// ===== hw/rtl/tilt_angles_to_quaternion_unit.sv =====
// top level: two tilt angles in, unit quaternion qX*qY out
//
// req channel: valid/ready transfer of first_tilt and second_tilt (Q3.13 rad)
// rsp channel: valid/ready transfer of quat_w/x/y/z (Q1.14, saturated)
// csr port: plain write, index 0 first axis heading, index 1 second heading;
//   write only while no transfer is in flight
// one fully pipelined path accepts a new pair every cycle
// latency: CORDIC_RUN + 10 cycles (16 steps: 26), set by the cordic cell
//   chain plus the multiply and hamilton product stages
//   (reduce, cells, axis mul, 2x hamilton, tilt mul, hamilton, output reg)
// four cordic chains run side by side: both half tilts and both headings
// whole pipeline advances together; a stalled result holds in the output
//   register and req_ready drops until rsp_ready returns
// reset clears the valid bits and loads the heading defaults (0 and pi/2)
module tilt_angles_to_quaternion_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_first_tilt,
   input  logic signed [15:0] req_second_tilt,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic signed [15:0] csr_data
);
   import tiltq_pkg::*;

   localparam int LAT = CORDIC_RUN + 10;

   // config registers
   logic signed [15:0] head_a_ff, head_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_a_ff <= 16'sd0;
         head_b_ff <= 16'sd12868;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FIRST_HEADING:  head_a_ff <= csr_data;
            REG_SECOND_HEADING: head_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: move whenever output is free or being taken
   logic adv;
   logic [LAT-1:0] vld_ff;
   assign adv = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end
   assign rsp_valid = vld_ff[LAT-1];

   // angle widening and half-turn reduction
   // lanes: 0 first tilt, 1 second tilt, 2 first heading, 3 second heading
   logic signed [AW-1:0] ang [4];
   logic signed [AW-1:0] red [4];
   lane_type pre_in [4];
   lane_type pre_ff [4];

   always_comb begin
      ang[0] = {{4{req_first_tilt[15]}}, req_first_tilt, 16'b0};
      ang[1] = {{4{req_second_tilt[15]}}, req_second_tilt, 16'b0};
      ang[2] = {{3{head_a_ff[15]}}, head_a_ff, 17'b0};
      ang[3] = {{3{head_b_ff[15]}}, head_b_ff, 17'b0};
      for (int l = 0; l < 4; l++) begin
         pre_in[l].x = Q30_GAIN;
         pre_in[l].y = '0;
         pre_in[l].neg = 1'b0;
         red[l] = ang[l];
         if (ang[l] > Q30_HALF_PI) begin
            red[l] = ang[l] - Q30_PI;
            pre_in[l].neg = 1'b1;
         end else if (ang[l] < -Q30_HALF_PI) begin
            red[l] = ang[l] + Q30_PI;
            pre_in[l].neg = 1'b1;
         end
         pre_in[l].z = red[l][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) pre_ff <= pre_in;
   end

   // cordic cell chains
   lane_type cell_link [CORDIC_RUN+1][4];

   genvar s, l;
   generate
      for (l = 0; l < 4; l++) begin : g_lane
         assign cell_link[0][l] = pre_ff[l];
         for (s = 0; s < CORDIC_RUN; s++) begin : g_step
            tiltq_cordic_cell u_cell (
               .clock    (clock),
               .en       (adv),
               .step     (STEP_W'(s)),
               .cell_in  (cell_link[s][l]),
               .cell_out (cell_link[s+1][l])
            );
         end
      end
   endgenerate

   // undo the half-turn reduction by negation
   q30_type cs [4];
   q30_type sn [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cs[k] = cell_link[CORDIC_RUN][k].neg ? -cell_link[CORDIC_RUN][k].x
                                              :  cell_link[CORDIC_RUN][k].x;
         sn[k] = cell_link[CORDIC_RUN][k].neg ? -cell_link[CORDIC_RUN][k].y
                                              :  cell_link[CORDIC_RUN][k].y;
      end
   end

   // first axis scaling
   q30_type chx_ff, qx1_ff, qx2_ff, cb_ff, sb_ff, chy_ff, shy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         chx_ff <= cs[0];
         qx1_ff <= qmul(cs[2], sn[0]);
         qx2_ff <= qmul(sn[2], sn[0]);
         cb_ff  <= cs[3];
         sb_ff  <= sn[3];
         chy_ff <= cs[1];
         shy_ff <= sn[1];
      end
   end

   q30_type qx [4];
   q30_type qxc [4];
   q30_type vax [4];
   assign qx  = '{chx_ff, qx1_ff, qx2_ff, '0};
   assign qxc = '{chx_ff, -qx1_ff, -qx2_ff, '0};
   assign vax = '{'0, cb_ff, sb_ff, '0};

   // side delay line for qx and the second tilt terms
   q30_type qx_dl_ff [5][4];
   q30_type cy_dl_ff [4];
   q30_type sy_dl_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         qx_dl_ff[0] <= qx;
         cy_dl_ff[0] <= chy_ff;
         sy_dl_ff[0] <= shy_ff;
         for (int d = 1; d < 5; d++) qx_dl_ff[d] <= qx_dl_ff[d-1];
         for (int d = 1; d < 4; d++) begin
            cy_dl_ff[d] <= cy_dl_ff[d-1];
            sy_dl_ff[d] <= sy_dl_ff[d-1];
         end
      end
   end

   // turn second axis by inverse of qx
   q30_type tq [4];
   q30_type vr [4];
   tiltq_hamilton u_ham_t (
      .clock (clock), .en (adv), .a (qxc), .b (vax), .r (tq)
   );
   tiltq_hamilton u_ham_v (
      .clock (clock), .en (adv), .a (tq), .b (qx_dl_ff[1]), .r (vr)
   );

   // second rotation quaternion
   q30_type qy_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         qy_ff[0] <= cy_dl_ff[3];
         for (int k = 1; k < 4; k++) qy_ff[k] <= qmul(sy_dl_ff[3], vr[k]);
      end
   end

   q30_type res [4];
   tiltq_hamilton u_ham_r (
      .clock (clock), .en (adv), .a (qx_dl_ff[4]), .b (qy_ff), .r (res)
   );

   // output register, holds while stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_quat_w <= to_q14(res[0]);
         rsp_quat_x <= to_q14(res[1]);
         rsp_quat_y <= to_q14(res[2]);
         rsp_quat_z <= to_q14(res[3]);
      end
   end

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer not tracked");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_z))
      else $error("stalled result changed");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384
                 && rsp_quat_x <= 16'sd16384 && rsp_quat_x >= -16'sd16384)
      else $error("result outside saturation range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
